// File: rtl/hrlp_pkg.sv
`default_nettype none

package hrlp_pkg;

  localparam int CountBits = 16;
  localparam int CapBits   = 16;
  localparam int NumLits   = 4;

  typedef enum logic [2:0] {
    STAGE_METHOD  = 3'd0,
    STAGE_PATH    = 3'd1,
    STAGE_QUERY   = 3'd2,
    STAGE_VERSION = 3'd3,
    STAGE_AWAIT_LF = 3'd4,
    STAGE_HEADERS = 3'd5,
    STAGE_ERROR   = 3'd6
  } stage_e;

  localparam logic [1:0] METHOD_UNKNOWN = 2'd0;
  localparam logic [1:0] METHOD_GET     = 2'd1;
  localparam logic [1:0] METHOD_POST    = 2'd2;
  localparam logic [1:0] METHOD_UNSUPP  = 2'd3;

  localparam logic [1:0] STATUS_NONE        = 2'd0;
  localparam logic [1:0] STATUS_BAD_REQ     = 2'd1;
  localparam logic [1:0] STATUS_NOT_ALLOWED = 2'd2;
  localparam logic [1:0] STATUS_BAD_VERSION = 2'd3;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_PATH  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam int LIT_GET    = 0;
  localparam int LIT_POST   = 1;
  localparam int LIT_HTTP11 = 2;
  localparam int LIT_HTTP10 = 3;

  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_QM = 8'h3f;
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  localparam logic [7:0] LitText [NumLits][8] = '{
    '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4f, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e, 8'h31},
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e, 8'h30}
  };

  localparam logic [3:0] LitLen [NumLits] = '{4'd3, 4'd4, 4'd8, 4'd8};

  typedef struct packed {
    stage_e      stage;
    logic [1:0]  method_code;
    logic [1:0]  status_code;
    logic [1:0]  field_kind;
    logic        byte_kept;
    logic [7:0]  field_byte;
    logic        field_end;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/hrlp_core.sv
`default_nettype none

// Parser state and the per-word step.
module hrlp_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cap_we_i,
  input  logic [hrlp_pkg::CapBits-1:0] cap_i,
  input  logic                        step_i,
  input  logic [7:0]                  byte_i,
  output hrlp_pkg::result_t           result_o
);

  hrlp_pkg::stage_e                 stage_q, stage_d, next_stage;
  logic [hrlp_pkg::CountBits-1:0]   count_q, count_d;
  logic [hrlp_pkg::NumLits-1:0]     flags_q, flags_d;
  logic [1:0]                       method_q, method_d;
  logic [1:0]                       status_q, status_d;
  logic [hrlp_pkg::CapBits-1:0]     cap_q;

  logic [hrlp_pkg::CapBits-1:0]     limit;
  logic                             room;
  logic                             enter;
  logic [hrlp_pkg::NumLits-1:0]     hit;
  logic [hrlp_pkg::NumLits-1:0]     matched;
  logic [1:0]                       kind;
  logic                             kept;
  logic                             fend;

  always_comb begin
    limit = (cap_q == '0) ? '0 : cap_q - 1'b1;
    room  = ({{(32-hrlp_pkg::CountBits){1'b0}}, count_q} <
             {{(32-hrlp_pkg::CapBits){1'b0}}, limit}) && (count_q != '1);
    for (int i = 0; i < hrlp_pkg::NumLits; i++) begin
      hit[i] = (count_q < hrlp_pkg::CountBits'(hrlp_pkg::LitLen[i])) &&
               (hrlp_pkg::LitText[i][count_q[2:0]] == byte_i);
      matched[i] = flags_q[i] &&
                   (count_q == hrlp_pkg::CountBits'(hrlp_pkg::LitLen[i]));
    end
  end

  always_comb begin
    count_d    = count_q;
    flags_d    = flags_q;
    method_d   = method_q;
    status_d   = status_q;
    next_stage = stage_q;
    enter      = 1'b0;
    kind       = hrlp_pkg::KIND_OTHER;
    kept       = 1'b0;
    fend       = 1'b0;
    case (stage_q)
      hrlp_pkg::STAGE_METHOD: begin
        if (byte_i == hrlp_pkg::CHAR_SP) begin
          enter = 1'b1;
          if (matched[hrlp_pkg::LIT_GET]) begin
            method_d   = hrlp_pkg::METHOD_GET;
            next_stage = hrlp_pkg::STAGE_PATH;
          end else if (matched[hrlp_pkg::LIT_POST]) begin
            method_d   = hrlp_pkg::METHOD_POST;
            next_stage = hrlp_pkg::STAGE_PATH;
          end else begin
            method_d   = hrlp_pkg::METHOD_UNSUPP;
            status_d   = hrlp_pkg::STATUS_NOT_ALLOWED;
            next_stage = hrlp_pkg::STAGE_ERROR;
          end
        end else if (room) begin
          count_d = count_q + 1'b1;
          flags_d = flags_q & hit;
        end
      end
      hrlp_pkg::STAGE_PATH, hrlp_pkg::STAGE_QUERY: begin
        kind = (stage_q == hrlp_pkg::STAGE_PATH) ? hrlp_pkg::KIND_PATH
                                                 : hrlp_pkg::KIND_QUERY;
        if (byte_i == hrlp_pkg::CHAR_SP ||
            (byte_i == hrlp_pkg::CHAR_QM && stage_q == hrlp_pkg::STAGE_PATH)) begin
          fend       = 1'b1;
          enter      = 1'b1;
          next_stage = (byte_i == hrlp_pkg::CHAR_QM) ? hrlp_pkg::STAGE_QUERY
                                                     : hrlp_pkg::STAGE_VERSION;
        end else if (room) begin
          kept    = 1'b1;
          count_d = count_q + 1'b1;
          flags_d = flags_q & hit;
        end
      end
      hrlp_pkg::STAGE_VERSION: begin
        if (byte_i == hrlp_pkg::CHAR_CR) begin
          enter = 1'b1;
          if (matched[hrlp_pkg::LIT_HTTP11]) begin
            next_stage = hrlp_pkg::STAGE_AWAIT_LF;
          end else if (matched[hrlp_pkg::LIT_HTTP10]) begin
            status_d   = hrlp_pkg::STATUS_BAD_VERSION;
            next_stage = hrlp_pkg::STAGE_ERROR;
          end else begin
            status_d   = hrlp_pkg::STATUS_BAD_REQ;
            next_stage = hrlp_pkg::STAGE_ERROR;
          end
        end else if (room) begin
          count_d = count_q + 1'b1;
          flags_d = flags_q & hit;
        end
      end
      hrlp_pkg::STAGE_AWAIT_LF: begin
        enter = 1'b1;
        if (byte_i == hrlp_pkg::CHAR_LF) begin
          next_stage = hrlp_pkg::STAGE_HEADERS;
        end else begin
          status_d   = hrlp_pkg::STATUS_BAD_REQ;
          next_stage = hrlp_pkg::STAGE_ERROR;
        end
      end
      default: begin
      end
    endcase
    stage_d = next_stage;
    if (enter) begin
      count_d = '0;
      flags_d = '1;
    end
  end

  always_comb begin
    result_o.stage       = stage_d;
    result_o.method_code = method_d;
    result_o.status_code = status_d;
    result_o.field_kind  = kind;
    result_o.byte_kept   = kept;
    result_o.field_byte  = kept ? byte_i : 8'h00;
    result_o.field_end   = fend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= hrlp_pkg::STAGE_METHOD;
      count_q  <= '0;
      flags_q  <= '1;
      method_q <= hrlp_pkg::METHOD_UNKNOWN;
      status_q <= hrlp_pkg::STATUS_NONE;
    end else if (step_i) begin
      stage_q  <= stage_d;
      count_q  <= count_d;
      flags_q  <= flags_d;
      method_q <= method_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= hrlp_pkg::CapBits'(128);
    end else if (cap_we_i) begin
      cap_q <= cap_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/http_request_line_parser.sv
`default_nettype none

// Parses an HTTP request line one byte per word and returns one result word per
// input word, in order. The parser state updates at
// the accepting edge and the result lands in an output register backed by a
// one-entry skid register, so a byte can be taken every cycle while the
// downstream side keeps pace; in_stall_o rises only once the skid entry holds a
// result. Path and query characters are echoed with field_kind and byte_kept;
// errors park the parser in the error stage with a status code until reset.
// field_capacity may be written only while no result is pending.
module http_request_line_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        field_capacity_we_i,
  input  logic [15:0]                 field_capacity_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  in_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  stage_o,
  output logic [1:0]                  method_code_o,
  output logic [1:0]                  status_code_o,
  output logic [1:0]                  field_kind_o,
  output logic                        byte_kept_o,
  output logic [7:0]                  field_byte_o,
  output logic                        field_end_o
);

  hrlp_pkg::result_t result;
  hrlp_pkg::result_t out_q;
  hrlp_pkg::result_t skid_q;
  logic              out_valid_q;
  logic              skid_valid_q;
  logic              in_acc;
  logic              out_pop;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_pop    = out_valid_q && !out_stall_i;

  hrlp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cap_we_i (field_capacity_we_i),
    .cap_i    (field_capacity_i),
    .step_i   (in_acc),
    .byte_i   (in_byte_i),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_pop) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign stage_o       = out_q.stage;
  assign method_code_o = out_q.method_code;
  assign status_code_o = out_q.status_code;
  assign field_kind_o  = out_q.field_kind;
  assign byte_kept_o   = out_q.byte_kept;
  assign field_byte_o  = out_q.field_byte;
  assign field_end_o   = out_q.field_end;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_kept_in_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (byte_kept_o || field_end_o)) |->
      (field_kind_o == hrlp_pkg::KIND_PATH || field_kind_o == hrlp_pkg::KIND_QUERY))
    else $error("field byte outside path or query");

  a_error_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((stage_o == hrlp_pkg::STAGE_ERROR) == (status_code_o != hrlp_pkg::STATUS_NONE)))
    else $error("error stage and status disagree");

endmodule

`default_nettype wire

// File: tb/sv/request_line_checker.sv
module request_line_checker
  import hrlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cap_we_i,
  input  logic [15:0] cap_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  stage_i,
  input  logic [1:0]  method_code_i,
  input  logic [1:0]  status_code_i,
  input  logic [1:0]  field_kind_i,
  input  logic        byte_kept_i,
  input  logic [7:0]  field_byte_i,
  input  logic        field_end_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          checked_o,
  output int          kept_o,
  output logic [6:0]  stages_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] lit_txt [NumLits];
  int          lit_len [NumLits];
  stage_e      cur_stage;
  logic [15:0] cap_q;
  logic [15:0] kept_n;
  logic [3:0]  lit_ok;
  logic [1:0]  method_q;
  logic [1:0]  status_q;
  result_t     expected_words [$];
  result_t     want;
  result_t     step_res;

  initial begin
    lit_txt[LIT_GET]    = "GET";
    lit_txt[LIT_POST]   = "POST";
    lit_txt[LIT_HTTP11] = "HTTP/1.1";
    lit_txt[LIT_HTTP10] = "HTTP/1.0";
    lit_len[LIT_GET]    = 3;
    lit_len[LIT_POST]   = 4;
    lit_len[LIT_HTTP11] = 8;
    lit_len[LIT_HTTP10] = 8;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches_o++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
    if (got !== exp_v) begin
      report_mismatch($sformatf("word %0d: %s is %0h, expected %0h", checked_o, name, got,
                                exp_v));
    end
  endtask

  task automatic enter_stage(input stage_e s);
    cur_stage = s;
    kept_n    = '0;
    lit_ok    = '1;
  endtask

  function automatic bit lit_hit(input int i);
    return lit_ok[i] && (int'(kept_n) == lit_len[i]);
  endfunction

  // Store one field character if there is room; literal flags track the kept text.
  task automatic keep_char(input logic [7:0] c, output bit kept);
    int limit;
    limit = (cap_q == 16'd0) ? 0 : int'(cap_q) - 1;
    kept  = 1'b0;
    if (int'(kept_n) < limit && kept_n != '1) begin
      for (int i = 0; i < NumLits; i++) begin
        if (int'(kept_n) >= lit_len[i]) begin
          lit_ok[i] = 1'b0;
        end else if (lit_txt[i][8 * (lit_len[i] - 1 - int'(kept_n)) +: 8] != c) begin
          lit_ok[i] = 1'b0;
        end
      end
      kept_n = kept_n + 16'd1;
      kept   = 1'b1;
    end
  endtask

  task automatic parse_byte(input logic [7:0] c, output result_t r);
    bit         kept;
    bit         stored;
    bit         fend;
    logic [1:0] kind;
    kept = 1'b0;
    fend = 1'b0;
    kind = KIND_OTHER;
    case (cur_stage)
      STAGE_METHOD: begin
        if (c == CHAR_SP) begin
          if (lit_hit(LIT_GET)) begin
            method_q = METHOD_GET;
            enter_stage(STAGE_PATH);
          end else if (lit_hit(LIT_POST)) begin
            method_q = METHOD_POST;
            enter_stage(STAGE_PATH);
          end else begin
            method_q = METHOD_UNSUPP;
            status_q = STATUS_NOT_ALLOWED;
            enter_stage(STAGE_ERROR);
          end
        end else begin
          keep_char(c, stored);
        end
      end
      STAGE_PATH, STAGE_QUERY: begin
        kind = (cur_stage == STAGE_PATH) ? KIND_PATH : KIND_QUERY;
        if (c == CHAR_SP || (c == CHAR_QM && cur_stage == STAGE_PATH)) begin
          fend = 1'b1;
          enter_stage((c == CHAR_QM) ? STAGE_QUERY : STAGE_VERSION);
        end else begin
          keep_char(c, kept);
        end
      end
      STAGE_VERSION: begin
        if (c == CHAR_CR) begin
          if (lit_hit(LIT_HTTP11)) begin
            enter_stage(STAGE_AWAIT_LF);
          end else if (lit_hit(LIT_HTTP10)) begin
            status_q = STATUS_BAD_VERSION;
            enter_stage(STAGE_ERROR);
          end else begin
            status_q = STATUS_BAD_REQ;
            enter_stage(STAGE_ERROR);
          end
        end else begin
          keep_char(c, stored);
        end
      end
      STAGE_AWAIT_LF: begin
        if (c == CHAR_LF) begin
          enter_stage(STAGE_HEADERS);
        end else begin
          status_q = STATUS_BAD_REQ;
          enter_stage(STAGE_ERROR);
        end
      end
      default: ;
    endcase
    r.stage       = cur_stage;
    r.method_code = method_q;
    r.status_code = status_q;
    r.field_kind  = kind;
    r.byte_kept   = kept;
    r.field_byte  = kept ? c : 8'h00;
    r.field_end   = fend;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    = 16'd128;
      method_q = METHOD_UNKNOWN;
      status_q = STATUS_NONE;
      enter_stage(STAGE_METHOD);
      expected_words.delete();
      mismatches_o  = 0;
      pending_o     = 0;
      checked_o     = 0;
      kept_o        = 0;
      stages_seen_o = '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing expected", checked_o));
        end else begin
          want = expected_words.pop_front();
          check_field("stage", 8'(stage_i), 8'(want.stage));
          check_field("method_code", 8'(method_code_i), 8'(want.method_code));
          check_field("status_code", 8'(status_code_i), 8'(want.status_code));
          check_field("field_kind", 8'(field_kind_i), 8'(want.field_kind));
          check_field("byte_kept", 8'(byte_kept_i), 8'(want.byte_kept));
          check_field("field_byte", field_byte_i, want.field_byte);
          check_field("field_end", 8'(field_end_i), 8'(want.field_end));
        end
        checked_o++;
      end
      if (in_valid_i && !in_stall_i) begin
        parse_byte(in_byte_i, step_res);
        expected_words.push_back(step_res);
        stages_seen_o[step_res.stage] = 1'b1;
        if (step_res.byte_kept) begin
          kept_o++;
        end
      end
      if (cap_we_i) begin
        cap_q = cap_i;
      end
      pending_o = expected_words.size();
    end
  end

endmodule

// File: tb/sv/http_request_line_parser_tb.sv
module http_request_line_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hrlp_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 300;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cap_we    = 1'b0;
  logic [15:0] cap_data  = 16'd0;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = 8'h00;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  stage;
  logic [1:0]  method_code;
  logic [1:0]  status_code;
  logic [1:0]  field_kind;
  logic        byte_kept;
  logic [7:0]  field_byte;
  logic        field_end;

  int          mismatches;
  int          pending;
  int          checked;
  int          kept_chars;
  logic [6:0]  stages_seen;

  logic [7:0]  tx_q [$];
  int          words_in  = 0;
  int          words_out = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  http_request_line_parser u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .field_capacity_we_i (cap_we),
    .field_capacity_i    (cap_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .in_byte_i           (in_byte),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .stage_o             (stage),
    .method_code_o       (method_code),
    .status_code_o       (status_code),
    .field_kind_o        (field_kind),
    .byte_kept_o         (byte_kept),
    .field_byte_o        (field_byte),
    .field_end_o         (field_end)
  );

  request_line_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cap_we_i      (cap_we),
    .cap_i         (cap_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_byte_i     (in_byte),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .stage_i       (stage),
    .method_code_i (method_code),
    .status_code_i (status_code),
    .field_kind_i  (field_kind),
    .byte_kept_i   (byte_kept),
    .field_byte_i  (field_byte),
    .field_end_i   (field_end),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .checked_o     (checked),
    .kept_o        (kept_chars),
    .stages_seen_o (stages_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sender: random gaps, none while words 600..799 go in.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        words_in <= words_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (tx_q.size() != 0 &&
            ((words_in >= 600 && words_in < 800) || $urandom_range(99) >= 10)) begin
          in_valid <= 1'b1;
          in_byte  <= tx_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold-off after 200 words, calm between 600 and 799.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_out <= words_out + 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && words_out >= 200) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(words_out >= 600 && words_out < 800) && ($urandom_range(99) < 10);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no word moved for %0d cycles", WatchdogLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (tx_q.size() != 0 || in_valid || pending != 0);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    wait_drained();
    @(posedge clk);
    cap_we   <= 1'b1;
    cap_data <= v;
    @(posedge clk);
    cap_we   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      tx_q.push_back(s[i]);
    end
  endtask

  // Random field characters; space never appears, '?' only in the query.
  task automatic push_field(input int n, input bit in_path);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) begin
        case ($urandom_range(4))
          0:       b = CHAR_CR;
          1:       b = CHAR_LF;
          2:       b = CHAR_QM;
          3:       b = 8'h00;
          default: b = 8'hff;
        endcase
      end else begin
        b = 8'($urandom_range(255));
      end
      while (b == CHAR_SP || (in_path && b == CHAR_QM)) begin
        b = 8'($urandom_range(255));
      end
      tx_q.push_back(b);
    end
  endtask

  function automatic logic [15:0] pick_capacity(input int sel);
    case (sel)
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd2;
      3:       return 16'hffff;
      4:       return 16'($urandom_range(64, 3));
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  initial begin
    bit          has_query;
    int          rot;
    int          len_hi;
    int          ver;
    logic [15:0] cap;
    string       vtext;

    @(posedge rst_n);
    @(negedge clk);

    case ($urandom_range(3))
      0:       cap = 16'd5;
      1:       cap = 16'd128;
      2:       cap = 16'hffff;
      default: cap = 16'($urandom_range(300, 5));
    endcase
    write_capacity(cap);

    // mostly a good method; now and then an empty, unknown or NUL-bearing one
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(5))
        0: push_text("");
        1: push_text("PUT");
        2: push_text("GE");
        3: push_text("GETS");
        4: push_text("get");
        default: begin
          push_text("GE");
          tx_q.push_back(8'h00);
        end
      endcase
    end else if ($urandom_range(1) == 0) begin
      push_text("GET");
    end else begin
      push_text("POST");
    end
    push_text(" /");
    tx_q.push_back(8'h00);
    tx_q.push_back(8'hff);
    tx_q.push_back(8'h55);
    tx_q.push_back(8'haa);
    tx_q.push_back(8'h80);
    tx_q.push_back(8'h7f);
    tx_q.push_back(8'h01);
    tx_q.push_back(8'hfe);

    has_query = ($urandom_range(3) != 0);
    len_hi    = has_query ? 110 : 200;
    rot       = $urandom_range(5);
    for (int k = 0; k < 6; k++) begin
      write_capacity(pick_capacity((k + rot) % 6));
      push_field($urandom_range(len_hi, len_hi - 60), 1'b1);
    end
    if (has_query) begin
      push_text("?");
      rot = $urandom_range(5);
      for (int k = 0; k < 6; k++) begin
        write_capacity(pick_capacity((k + rot) % 6));
        push_field($urandom_range(len_hi, len_hi - 60), 1'b0);
      end
    end
    push_text(" ");

    // capacity 9 keeps exactly eight version characters; 5 truncates them
    ver = $urandom_range(5);
    write_capacity((ver == 4) ? 16'd5 : (($urandom_range(1) == 0) ? 16'd9 : 16'hffff));
    case (ver)
      2:       vtext = "HTTP/1.0";
      5:       vtext = "HTTP/2";
      default: vtext = "HTTP/1.1";
    endcase
    push_text(vtext);
    if (ver == 5 && $urandom_range(1) == 0) begin
      tx_q.push_back(8'h00);
    end
    tx_q.push_back(CHAR_CR);
    tx_q.push_back((ver == 3) ? 8'h58 : CHAR_LF);
    repeat (8) tx_q.push_back(8'($urandom_range(255)));

    wait_drained();
    repeat (4) @(posedge clk);

    $display("request line: %0d bytes checked, %0d path/query characters kept, stages %b",
             checked, kept_chars, stages_seen);
    $display("ended in stage %0d with method %0d and status %0d, query %0s",
             stage, method_code, status_code, has_query ? "present" : "absent");
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
